### hw/rtl/postfix_stack_evaluator_defines.svh
// assertion helpers used by the evaluator datapath
`ifndef POSTFIX_STACK_EVALUATOR_DEFINES_SVH
`define POSTFIX_STACK_EVALUATOR_DEFINES_SVH

// same-cycle implication, reset masked
`define PSE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, reset masked
`define PSE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/pse_pkg.sv
package pse_pkg;

	// symbol codes
	localparam logic [7:0] SYM_ADD  = 8'h2B;
	localparam logic [7:0] SYM_SUB  = 8'h2D;
	localparam logic [7:0] SYM_MUL  = 8'h2A;
	localparam logic [7:0] SYM_DIV  = 8'h2F;
	localparam logic [7:0] SYM_ZERO = 8'h30;

	// sticky flag positions
	localparam int FLAG_UNDER = 0;
	localparam int FLAG_OVER  = 1;
	localparam int FLAG_DIV0  = 2;
	localparam int NUM_FLAGS  = 3;

	localparam int RESULT_WIDTH = 32;
	localparam int DEPTH_OUT_WIDTH = 7;

	typedef struct packed {
		logic latch_in;
		logic push_opd;
		logic rd_left;
		logic commit_alu;
		logic md_start;
		logic commit_md;
		logic emit;
	} pse_cmd_t;

	typedef struct packed {
		logic is_op;
		logic is_muldiv;
		logic last;
		logic md_done;
		logic out_busy;
	} pse_status_t;

endpackage

### hw/rtl/pse_in_if.sv
interface pse_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] symbol;
	logic       last;

	modport source (output valid, output symbol, output last, input ready);
	modport sink   (input valid, input symbol, input last, output ready);
endinterface

### hw/rtl/pse_out_if.sv
interface pse_out_if;
	logic                                     valid;
	logic                                     ready;
	logic signed [pse_pkg::RESULT_WIDTH-1:0]  value;
	logic                                     underflow_seen;
	logic                                     overflow_seen;
	logic                                     divide_by_zero_seen;
	logic [pse_pkg::DEPTH_OUT_WIDTH-1:0]      final_depth;

	modport source (output valid, output value, output underflow_seen, output overflow_seen,
		output divide_by_zero_seen, output final_depth, input ready);
	modport sink (input valid, input value, input underflow_seen, input overflow_seen,
		input divide_by_zero_seen, input final_depth, output ready);
endinterface

### hw/rtl/postfix_stack_evaluator.sv
// operand symbol: pushed in ST_DECODE; add or subtract: left operand read in ST_DECODE and
// commit in ST_LOAD; multiply or divide: the one-bit-per-cycle mul/div unit starts in ST_LOAD,
// commit from ST_MDWAIT on done; last-marked symbols emit in ST_FINISH once the slot is free
// one symbol in flight at a time; a waiting result holds off only the next last-marked symbol
// reset (arst_n low) empties the stack, clears flags and the result slot; memory is not cleared
module postfix_stack_evaluator #(
	parameter int STACK_DEPTH = 64,
	parameter int VALUE_WIDTH = 32
) (
	input logic        clk,
	input logic        arst_n,
	pse_in_if.sink     expr,
	pse_out_if.source  result
);
	// command and status between sequencer and datapath
	pse_pkg::pse_cmd_t    cmd;
	pse_pkg::pse_status_t status;

	// sequencer: one transaction on expr is worked through in full before
	// the next is taken; operators read the left operand from the stack
	// memory, then either commit at once (add, subtract) or run the
	// iterative mul/div unit and commit when it reports done
	pse_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (expr.valid),
		.in_ready (expr.ready),
		.status   (status),
		.cmd      (cmd)
	);

	// datapath: top-of-stack register, stack memory below it, sticky
	// flags, mul/div unit and the result register feeding the result channel
	pse_datapath #(
		.W     (VALUE_WIDTH),
		.DEPTH (STACK_DEPTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.symbol        (expr.symbol),
		.last          (expr.last),
		.out_valid     (result.valid),
		.out_ready     (result.ready),
		.out_value     (result.value),
		.out_underflow (result.underflow_seen),
		.out_overflow  (result.overflow_seen),
		.out_div_zero  (result.divide_by_zero_seen),
		.out_depth     (result.final_depth)
	);
endmodule

### hw/rtl/pse_muldiv.sv
module pse_muldiv #(
	parameter int W = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic         is_div,
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	output logic         done,
	output logic [W-1:0] result,
	output logic         div_zero
);
	localparam int CNW = $clog2(W + 1);

	logic           busy_q;
	logic [CNW-1:0] cnt_q;
	logic [W:0]     rem_q;
	logic [W-1:0]   quo_q;
	logic [W-1:0]   dsr_q;
	logic           div_q;
	logic           neg_q;
	logic           dz_q;

	logic           na;
	logic           nb;
	logic [W-1:0]   ua;
	logic [W-1:0]   ub;
	logic [W:0]     rem_sh;
	logic [W:0]     diff;

	assign na = a[W-1];
	assign nb = b[W-1];
	assign ua = (is_div && na) ? (~a + W'(1)) : a;
	assign ub = (is_div && nb) ? (~b + W'(1)) : b;

	assign rem_sh = {rem_q[W-1:0], quo_q[W-1]};
	assign diff   = rem_sh - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNW'(W);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - CNW'(1);
			end
		end
	end

	// one quotient bit or one multiplier bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= ua;
			dsr_q <= ub;
			div_q <= is_div;
			neg_q <= na ^ nb;
			dz_q  <= (ub == '0);
		end else if (busy_q && cnt_q != '0) begin
			if (div_q) begin
				if (!diff[W]) begin
					rem_q <= diff;
					quo_q <= {quo_q[W-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					quo_q <= {quo_q[W-2:0], 1'b0};
				end
			end else begin
				if (quo_q[0]) begin
					rem_q <= {1'b0, rem_q[W-1:0] + dsr_q};
				end
				dsr_q <= {dsr_q[W-2:0], 1'b0};
				quo_q <= {1'b0, quo_q[W-1:1]};
			end
		end
	end

	assign done     = busy_q && (cnt_q == '0);
	assign div_zero = div_q && dz_q;

	always_comb begin
		if (!div_q) begin
			result = rem_q[W-1:0];
		end else if (dz_q) begin
			result = '0;
		end else if (neg_q) begin
			result = ~quo_q + W'(1);
		end else begin
			result = quo_q;
		end
	end
endmodule

### hw/rtl/pse_datapath.sv
`include "postfix_stack_evaluator_defines.svh"

module pse_datapath #(
	parameter int W     = 32,
	parameter int DEPTH = 64
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  pse_pkg::pse_cmd_t                       cmd,
	output pse_pkg::pse_status_t                    status,
	input  logic [7:0]                              symbol,
	input  logic                                    last,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic signed [pse_pkg::RESULT_WIDTH-1:0] out_value,
	output logic                                    out_underflow,
	output logic                                    out_overflow,
	output logic                                    out_div_zero,
	output logic [pse_pkg::DEPTH_OUT_WIDTH-1:0]     out_depth
);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = $clog2(DEPTH);

	logic [W-1:0]                   stack_mem [DEPTH];
	logic [W-1:0]                   rd_q;
	logic [W-1:0]                   top_q;
	logic [CW-1:0]                  count_q;
	logic [pse_pkg::NUM_FLAGS-1:0]  flags_q;
	logic [7:0]                     sym_q;
	logic                           last_q;
	logic                           out_valid_q;

	logic [CW-1:0]  cnt_m1;
	logic [CW-1:0]  cnt_m2;
	logic           full;
	logic           two_up;
	logic           mem_we;
	logic           mem_re;
	logic signed [8:0] opd_wide;
	logic [W-1:0]   opd_val;
	logic [W-1:0]   right_v;
	logic [W-1:0]   left_v;
	logic [W-1:0]   alu_res;
	logic           md_done;
	logic [W-1:0]   md_res;
	logic           md_dz;
	logic           commit;
	logic [W-1:0]   commit_val;

	assign cnt_m1 = count_q - CW'(1);
	assign cnt_m2 = count_q - CW'(2);
	assign full   = (count_q == CW'(DEPTH));
	assign two_up = (count_q >= CW'(2));

	assign opd_wide = $signed({1'b0, sym_q}) - $signed({1'b0, pse_pkg::SYM_ZERO});
	assign opd_val  = W'(opd_wide);

	assign right_v = (count_q != '0) ? top_q : '1;
	assign left_v  = two_up ? rd_q : '1;
	assign alu_res = (sym_q == pse_pkg::SYM_SUB) ? (left_v - right_v) : (left_v + right_v);

	assign mem_we = cmd.push_opd && !full && (count_q != '0);
	assign mem_re = cmd.rd_left && two_up;

	assign commit     = cmd.commit_alu || cmd.commit_md;
	assign commit_val = cmd.commit_md ? md_res : alu_res;

	pse_muldiv #(.W(W)) u_muldiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.md_start),
		.is_div   (sym_q == pse_pkg::SYM_DIV),
		.a        (left_v),
		.b        (right_v),
		.done     (md_done),
		.result   (md_res),
		.div_zero (md_dz)
	);

	// top of stack lives in top_q, entries below it in the memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			stack_mem[cnt_m1[AW-1:0]] <= top_q;
		end
		if (mem_re) begin
			rd_q <= stack_mem[cnt_m2[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			sym_q  <= symbol;
			last_q <= last;
		end
		if (cmd.push_opd && !full) begin
			top_q <= opd_val;
		end else if (commit) begin
			top_q <= commit_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			flags_q <= '0;
		end else if (cmd.emit) begin
			count_q <= '0;
			flags_q <= '0;
		end else if (cmd.push_opd) begin
			if (full) begin
				flags_q[pse_pkg::FLAG_OVER] <= 1'b1;
			end else begin
				count_q <= count_q + CW'(1);
			end
		end else if (commit) begin
			count_q <= two_up ? cnt_m1 : CW'(1);
			if (!two_up) begin
				flags_q[pse_pkg::FLAG_UNDER] <= 1'b1;
			end
			if (cmd.commit_md && md_dz) begin
				flags_q[pse_pkg::FLAG_DIV0] <= 1'b1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_value     <= (count_q == '0) ? '1 : pse_pkg::RESULT_WIDTH'($signed(top_q));
			out_underflow <= flags_q[pse_pkg::FLAG_UNDER];
			out_overflow  <= flags_q[pse_pkg::FLAG_OVER];
			out_div_zero  <= flags_q[pse_pkg::FLAG_DIV0];
			out_depth     <= pse_pkg::DEPTH_OUT_WIDTH'(count_q);
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		status.is_op     = (sym_q == pse_pkg::SYM_ADD) || (sym_q == pse_pkg::SYM_SUB) ||
		                   (sym_q == pse_pkg::SYM_MUL) || (sym_q == pse_pkg::SYM_DIV);
		status.is_muldiv = (sym_q == pse_pkg::SYM_MUL) || (sym_q == pse_pkg::SYM_DIV);
		status.last      = last_q;
		status.md_done   = md_done;
		status.out_busy  = out_valid_q && !out_ready;
	end

	`PSE_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(DEPTH), "stack count past depth")
	`PSE_ASSERT_NEXT(a_emit_clears, clk, arst_n, cmd.emit, count_q == '0 && flags_q == '0 && out_valid_q, "emit did not clear state")
	`PSE_ASSERT_NOW(a_md_commit, clk, arst_n, cmd.commit_md, md_done, "muldiv commit without done")
endmodule

### hw/rtl/pse_ctrl.sv
module pse_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  pse_pkg::pse_status_t status,
	output pse_pkg::pse_cmd_t    cmd
);
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DECODE = 3'd1;
	localparam logic [2:0] ST_LOAD   = 3'd2;
	localparam logic [2:0] ST_MDWAIT = 3'd3;
	localparam logic [2:0] ST_FINISH = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic [2:0] after_item;

	assign in_ready   = (state_q == ST_IDLE);
	assign after_item = status.last ? ST_FINISH : ST_IDLE;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.latch_in = 1'b1;
					state_d      = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (status.is_op) begin
					cmd.rd_left = 1'b1;
					state_d     = ST_LOAD;
				end else begin
					cmd.push_opd = 1'b1;
					state_d      = after_item;
				end
			end
			ST_LOAD: begin
				if (status.is_muldiv) begin
					cmd.md_start = 1'b1;
					state_d      = ST_MDWAIT;
				end else begin
					cmd.commit_alu = 1'b1;
					state_d        = after_item;
				end
			end
			ST_MDWAIT: begin
				if (status.md_done) begin
					cmd.commit_md = 1'b1;
					state_d       = after_item;
				end
			end
			ST_FINISH: begin
				if (!status.out_busy) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule
